// File: rtl/kwsc_pkg.sv
// ----------------------------------------------------------------------------
// kwsc_pkg: shared constants and types of the keyword substitution cipher
// ASCII codes, action codes and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package kwsc_pkg;

  localparam int unsigned AlphaSize = 26;
  localparam int unsigned LetterW   = 5;

  localparam logic [LetterW-1:0] LastLetter = LetterW'(AlphaSize - 1);

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5a;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7a;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharNone   = 8'h00;

  localparam logic [1:0] ActKey     = 2'd0;
  localparam logic [1:0] ActFinish  = 2'd1;
  localparam logic [1:0] ActEncrypt = 2'd2;

  typedef struct packed {
    logic key_put;     // add the accepted key letter
    logic fill_start;  // start the finish walk over the alphabet
    logic fill_step;   // one letter of the finish walk
    logic enc_load;    // capture the accepted encrypt word, read the table
    logic out_load;    // load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic key_ready;
    logic walk_last;
  } dpath_sts_t;

endpackage

// File: rtl/kwsc_dpath.sv
// ----------------------------------------------------------------------------
// kwsc_dpath: key store and encryption datapath
// Cipher table, used-letter mask, fill count, finish walk and result register.
// ----------------------------------------------------------------------------
module kwsc_dpath import kwsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  input  logic [7:0]       char_code_i,
  output dpath_sts_t       sts_o,
  output logic [7:0]       cipher_char_o,
  output logic             error_o
);

  logic [LetterW-1:0]   table_q [AlphaSize];
  logic [AlphaSize-1:0] used_q, used_d;
  logic [LetterW-1:0]   fill_q, fill_d;
  logic [LetterW-1:0]   walk_q, walk_d;
  logic                 ready_q, ready_d;

  logic [LetterW-1:0]   rd_q;
  logic                 lower_q, space_q, kready_q;
  logic [7:0]           cipher_q;
  logic                 error_q;

  logic                 wr_en;
  logic [LetterW-1:0]   wr_addr, wr_data;

  logic                 is_upper, is_lower;
  logic [7:0]           up_off, lo_off;
  logic [LetterW-1:0]   up_idx, lo_idx;
  logic [AlphaSize-1:0] used_base;
  logic [LetterW-1:0]   fill_base;

  assign is_upper  = (char_code_i >= CharUpperA) && (char_code_i <= CharUpperZ);
  assign is_lower  = (char_code_i >= CharLowerA) && (char_code_i <= CharLowerZ);
  assign up_off    = char_code_i - CharUpperA;
  assign lo_off    = char_code_i - CharLowerA;
  assign up_idx    = up_off[LetterW-1:0];
  assign lo_idx    = lo_off[LetterW-1:0];
  // a key letter after a finished key starts a fresh key
  assign used_base = ready_q ? '0 : used_q;
  assign fill_base = ready_q ? '0 : fill_q;

  always_comb begin
    used_d  = used_q;
    fill_d  = fill_q;
    walk_d  = walk_q;
    ready_d = ready_q;
    wr_en   = 1'b0;
    wr_addr = fill_q;
    wr_data = walk_q;
    if (cmd_i.key_put && is_upper) begin
      ready_d = 1'b0;
      used_d  = used_base;
      fill_d  = fill_base;
      if (!used_base[up_idx]) begin
        wr_en   = 1'b1;
        wr_addr = fill_base;
        wr_data = up_idx;
        used_d  = used_base | (AlphaSize'(1) << up_idx);
        fill_d  = fill_base + LetterW'(1);
      end
    end
    if (cmd_i.fill_start) begin
      walk_d = '0;
    end
    if (cmd_i.fill_step) begin
      if (!used_q[walk_q]) begin
        wr_en  = 1'b1;
        used_d = used_q | (AlphaSize'(1) << walk_q);
        fill_d = fill_q + LetterW'(1);
      end
      walk_d = walk_q + LetterW'(1);
      if (walk_q == LastLetter) begin
        ready_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      fill_q  <= '0;
      walk_q  <= '0;
      ready_q <= 1'b0;
    end else begin
      used_q  <= used_d;
      fill_q  <= fill_d;
      walk_q  <= walk_d;
      ready_q <= ready_d;
    end
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.enc_load && is_lower) begin
      rd_q <= table_q[lo_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.enc_load) begin
      lower_q  <= is_lower;
      space_q  <= (char_code_i == CharSpace);
      kready_q <= ready_q;
    end
    if (cmd_i.out_load) begin
      if (kready_q && lower_q) begin
        cipher_q <= CharUpperA + 8'(rd_q);
        error_q  <= 1'b0;
      end else if (kready_q && space_q) begin
        cipher_q <= CharSpace;
        error_q  <= 1'b0;
      end else begin
        cipher_q <= CharNone;
        error_q  <= 1'b1;
      end
    end
  end

  assign sts_o.key_ready = ready_q;
  assign sts_o.walk_last = (walk_q == LastLetter);
  assign cipher_char_o   = cipher_q;
  assign error_o         = error_q;

endmodule

// File: rtl/kwsc_ctrl.sv
// ----------------------------------------------------------------------------
// kwsc_ctrl: sequencing controller
// Decodes accepted words, runs the finish walk and owns the output valid.
// ----------------------------------------------------------------------------
module kwsc_ctrl import kwsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  dpath_sts_t  sts_i,
  output ctrl_cmd_t   cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StFill = 2'd1;
  localparam logic [1:0] StResp = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (action_i)
            ActKey:     cmd_o.key_put = 1'b1;
            ActFinish: begin
              if (!sts_i.key_ready) begin
                cmd_o.fill_start = 1'b1;
                state_d          = StFill;
              end
            end
            ActEncrypt: begin
              cmd_o.enc_load = 1'b1;
              state_d        = StResp;
            end
            default: ;
          endcase
        end
      end
      StFill: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.walk_last) begin
          state_d = StIdle;
        end
      end
      StResp: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/keyword_substitution_cipher_core.sv
// ----------------------------------------------------------------------------
// keyword_substitution_cipher_core: keyword substitution key builder and cipher
// Key letter word: taken while idle. Finish word on an unfinished key: a table
// walk over the alphabet. Encrypt word: table read registered on accept, result
// register loaded once the output is free, and only then is the next word taken.
// Reset clears the key state (no key ready); the table holds no reset value
// and needs no clearing pass: a read result is used only with a finished key, and finishing writes every entry.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher_core import kwsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input word
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] char_code_i,
  // result word
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] cipher_char_o,
  output logic       error_o
);

  ctrl_cmd_t  cmd;
  dpath_sts_t sts;

  // Controller: word decode, 26-step finish walk, result handoff.
  kwsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: cipher table, used mask, fill count, result register.
  kwsc_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .char_code_i   (char_code_i),
    .sts_o         (sts),
    .cipher_char_o (cipher_char_o),
    .error_o       (error_o)
  );

  // ---- assertions ----
  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // an encrypt word holds off the next word until its result is loaded
  a_enc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && action_i == ActEncrypt) |=> !in_ready_o)
    else $error("input taken right after an encrypt word");

  // a finish on an unfinished key starts the walk
  a_fill_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && action_i == ActFinish && !sts.key_ready) |=> !in_ready_o)
    else $error("finish walk did not start");

  // an error result carries a zero character
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (cipher_char_o == CharNone))
    else $error("error result with nonzero character");

  // a good result is an uppercase letter or a space
  a_good_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !error_o) |->
      ((cipher_char_o == CharSpace) ||
       ((cipher_char_o >= CharUpperA) && (cipher_char_o <= CharUpperZ))))
    else $error("good result outside cipher alphabet");

endmodule
